### hw/rtl/mse_pkg.sv
// Shared types, constants and arithmetic helpers of the median/Sobel/contrast pixel enhancer.
package mse_pkg;

   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int QUEUE_DEPTH = 4;
   localparam int PIX_W = 24;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [10:0] FRAME_WIDTH_RESET = 11'd640;
   localparam logic [15:0] FRAME_HEIGHT_RESET = 16'd480;
   localparam logic [15:0] CONTRAST_GAIN_RESET = 16'd256;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH,
      CSR_FRAME_HEIGHT,
      CSR_MEDIAN_ENABLE,
      CSR_EDGE_ENABLE,
      CSR_CONTRAST_GAIN,
      CSR_BRIGHTNESS_OFFSET
   } mse_csr_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_WIN_IN,
      BK_MED1,
      BK_MED2,
      BK_WIN_MED,
      BK_GRAY,
      BK_GRAD,
      BK_SQ,
      BK_ROOT,
      BK_FIN
   } mse_back_state_type;

   typedef struct packed {
      logic med;
      logic emit;
      logic sobel;
      logic last;
   } mse_ctl_type;

   typedef logic [8:0][7:0] mse_nine_type;
   typedef logic [2:0][2:0][PIX_W-1:0] mse_win_type;

   localparam int MED_OPS = 19;
   localparam int MED_SPLIT = 10;
   localparam int MED_A [MED_OPS] = '{1,4,7,0,3,6,1,4,7,0,5,4,3,1,2,4,4,6,4};
   localparam int MED_B [MED_OPS] = '{2,5,8,1,4,7,2,5,8,3,8,7,6,4,5,7,2,4,2};

   // compare-exchange network, ops first..last_op; median ends in element 4
   function automatic mse_nine_type med_net(mse_nine_type v, int first, int last_op);
      mse_nine_type p;
      logic [7:0] t;
      p = v;
      for (int i = 0; i < MED_OPS; i++) begin
         if (i >= first && i <= last_op && p[MED_A[i]] > p[MED_B[i]]) begin
            t = p[MED_A[i]];
            p[MED_A[i]] = p[MED_B[i]];
            p[MED_B[i]] = t;
         end
      end
      return p;
   endfunction

   // channel k of the window: 0 red, 1 green, 2 blue
   function automatic mse_nine_type chan_nine(mse_win_type w, int k);
      mse_nine_type p;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            p[3*i+j] = w[i][j][8*k +: 8];
         end
      end
      return p;
   endfunction

   function automatic mse_win_type win_shift(mse_win_type w, logic [PIX_W-1:0] top,
                                             logic [PIX_W-1:0] mid, logic [PIX_W-1:0] pix);
      mse_win_type r;
      r = w;
      for (int i = 0; i < 3; i++) begin
         r[i][0] = w[i][1];
         r[i][1] = w[i][2];
      end
      r[0][2] = top;
      r[1][2] = mid;
      r[2][2] = pix;
      return r;
   endfunction

   // (29b+59g+11r)/100 by reciprocal multiply, with blue in p[23:16] as the window holds it
   function automatic logic [7:0] gray_of(logic [PIX_W-1:0] p);
      logic [14:0] s;
      logic [27:0] m;
      s = 15'(p[23:16]) * 15'd29 + 15'(p[15:8]) * 15'd59 + 15'(p[7:0]) * 15'd11;
      m = 28'(s) * 28'd5243;
      return m[26:19];
   endfunction

   function automatic logic [7:0] finish_chan(logic [7:0] c, logic [7:0] mag,
                                              logic [15:0] gain, logic signed [8:0] bright);
      logic [8:0] x9;
      logic [7:0] x;
      logic signed [9:0] d;
      logic signed [26:0] t;
      logic [7:0] y;
      logic signed [10:0] z;
      x9 = 9'(c) + 9'(mag);
      x = x9[8] ? 8'd255 : x9[7:0];
      d = $signed({2'b00, x}) - 10'sd128;
      t = $signed({1'b0, gain}) * d + 27'sd32768;
      if (t <= 27'sd0) begin
         y = 8'd0;
      end else if (t >= 27'sd65536) begin
         y = 8'd255;
      end else begin
         y = t[15:8];
      end
      z = $signed({3'b000, y}) + 11'(bright);
      if (z < 11'sd0) begin
         return 8'd0;
      end else if (z > 11'sd255) begin
         return 8'd255;
      end
      return z[7:0];
   endfunction

endpackage

### hw/rtl/median_sobel_contrast_enhance.sv
// Top level of the streaming RGB enhancer: register file, front end, queue and back end.
//
// Pixels enter in raster order; each pixel leaves 2*width+2 effective beats after it
// arrives, through an optional 3x3 median, Sobel sharpening, contrast and brightness.
// Flush beats (tuser high) are dropped while frame pixels are still due; once the whole
// frame is in, any beat pushes the pipeline. The front end takes one beat per cycle into a
// four-entry queue while the queue has room. For each beat the back-end sequencer does the
// line-store read-modify-write and a two-step median; a beat that yields no result ends
// there, and a result passes a finish step, with Sobel first gray, gradient, squaring and
// the serial 8-step square root. No clearing pass runs after reset.
module median_sobel_contrast_enhance
   import mse_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [23:0]            req_tdata,   // in_red, in_green, in_blue
   input  logic                   req_tuser,   // action
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [23:0]            rsp_tdata,   // out_red, out_green, out_blue
   output logic                   rsp_tlast,   // frame_last
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int DATA_W = PIX_W + 2 * AW + $bits(mse_ctl_type);

   logic [10:0] width_ff;
   logic [15:0] height_ff, gain_ff;
   logic median_ff, edge_ff;
   logic [8:0] bright_ff;

   logic push_valid, push_ready, pop_valid, pop_ready;
   logic [DATA_W-1:0] push_data, pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= FRAME_WIDTH_RESET;
         height_ff <= FRAME_HEIGHT_RESET;
         median_ff <= 1'b0;
         edge_ff <= 1'b0;
         gain_ff <= CONTRAST_GAIN_RESET;
         bright_ff <= '0;
      end else if (csr_we) begin
         unique case (mse_csr_type'(csr_index))
            CSR_FRAME_WIDTH: width_ff <= csr_wdata[10:0];
            CSR_FRAME_HEIGHT: height_ff <= csr_wdata;
            CSR_MEDIAN_ENABLE: median_ff <= csr_wdata[0];
            CSR_EDGE_ENABLE: edge_ff <= csr_wdata[0];
            CSR_CONTRAST_GAIN: gain_ff <= csr_wdata;
            CSR_BRIGHTNESS_OFFSET: bright_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   mse_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock(clock),
      .reset(reset),
      .frame_width(width_ff),
      .frame_height(height_ff),
      .median_enable(median_ff),
      .edge_enable(edge_ff),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data(push_data)
   );

   mse_queue #(.DATA_W(DATA_W)) u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data(push_data),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_data(pop_data)
   );

   mse_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock(clock),
      .reset(reset),
      .contrast_gain(gain_ff),
      .brightness_offset(bright_ff),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_data(pop_data),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

endmodule

### hw/rtl/mse_front.sv
// Front end: tracks frame position, drops idle flushes and classifies each effective beat.
module mse_front
   import mse_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
   localparam int AW = $clog2(MAX_WIDTH),
   localparam int DATA_W = PIX_W + 2 * AW + $bits(mse_ctl_type)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [10:0]       frame_width,
   input  logic [15:0]       frame_height,
   input  logic              median_enable,
   input  logic              edge_enable,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [23:0]       req_tdata,   // in_red, in_green, in_blue
   input  logic              req_tuser,   // action
   output logic              push_valid,
   input  logic              push_ready,
   output logic [DATA_W-1:0] push_data
);

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int CW1 = CW + 1;
   localparam int PW = CW + 2;

   logic [CW-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [15:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [PW-1:0] pend_ff, pend_in;

   logic [CW-1:0] w_eff, cc;
   logic [15:0] h_eff;
   logic in_done, drop, step;
   logic [PIX_W-1:0] pix;
   logic [AW-1:0] laddr, maddr;
   logic signed [17:0] cr;
   logic [16:0] orow_n;
   mse_ctl_type ctl;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff <= '0;
         in_row_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         pend_ff <= '0;
      end else begin
         in_col_ff <= in_col_in;
         in_row_ff <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         pend_ff <= pend_in;
      end
   end

   always_comb begin
      if (frame_width == 11'd0) begin
         w_eff = CW'(1);
      end else if (int'(frame_width) > MAX_WIDTH) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = CW'(frame_width);
      end
      h_eff = (frame_height == 16'd0) ? 16'd1 : frame_height;

      in_done = in_row_ff >= h_eff;
      drop = !in_done && req_tuser;
      req_tready = push_ready;
      push_valid = req_tvalid && !drop;
      step = req_tvalid && push_ready && !drop;

      pix = in_done ? '0 : {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]};
      laddr = (int'(in_col_ff) < MAX_WIDTH) ? in_col_ff[AW-1:0] : '0;
      cc = (in_col_ff == '0) ? w_eff - CW'(1) : in_col_ff - CW'(1);
      maddr = (int'(cc) < MAX_WIDTH) ? cc[AW-1:0] : '0;
      cr = $signed({2'b00, in_row_ff}) - 18'sd1 - ((in_col_ff == '0) ? 18'sd1 : 18'sd0);

      ctl.med = median_enable && cr >= 18'sd1 && cr <= $signed({2'b00, h_eff}) - 18'sd2 &&
                cc != '0 && CW1'(cc) + CW1'(2) <= CW1'(w_eff);
      ctl.sobel = edge_enable && out_row_ff != 16'd0 && 17'(out_row_ff) + 17'd2 <= 17'(h_eff) &&
                  out_col_ff != '0 && CW1'(out_col_ff) + CW1'(2) <= CW1'(w_eff);
      ctl.last = (17'(out_row_ff) + 17'd1 == 17'(h_eff)) &&
                 (CW1'(out_col_ff) + CW1'(1) == CW1'(w_eff));
      ctl.emit = pend_ff >= PW'({w_eff, 1'b0}) + PW'(2);

      push_data = {pix, laddr, maddr, ctl};

      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      pend_in = pend_ff;
      orow_n = 17'(out_row_ff);

      if (step) begin
         if (CW1'(in_col_ff) + CW1'(1) >= CW1'(w_eff)) begin
            in_col_in = '0;
            if (!in_done) begin
               in_row_in = in_row_ff + 16'd1;
            end
         end else begin
            in_col_in = in_col_ff + CW'(1);
         end

         if (!ctl.emit) begin
            pend_in = pend_ff + PW'(1);
         end else begin
            if (CW1'(out_col_ff) + CW1'(1) >= CW1'(w_eff)) begin
               out_col_in = '0;
               orow_n = 17'(out_row_ff) + 17'd1;
            end else begin
               out_col_in = out_col_ff + CW'(1);
            end
            out_row_in = orow_n[15:0];
            if (orow_n >= 17'(h_eff)) begin
               in_col_in = '0;
               in_row_in = '0;
               out_col_in = '0;
               out_row_in = '0;
               pend_in = '0;
            end
         end
      end
   end

endmodule

### hw/rtl/mse_queue.sv
// Short FIFO between the front end and the back end.
module mse_queue
   import mse_pkg::*;
#(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);

   localparam int QA = $clog2(QUEUE_DEPTH);
   localparam int QC = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [QA-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QC-1:0] count_ff, count_in;
   logic do_push, do_pop;

   always_comb begin
      push_ready = count_ff != QC'(QUEUE_DEPTH);
      pop_valid = count_ff != '0;
      pop_data = slot_ff[rd_ff];
      do_push = push_valid && push_ready;
      do_pop = pop_valid && pop_ready;
      wr_in = do_push ? wr_ff + QA'(1) : wr_ff;
      rd_in = do_pop ? rd_ff + QA'(1) : rd_ff;
      count_in = count_ff + QC'(do_push) - QC'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/mse_back.sv
// Back end: line stores, windows, median, Sobel magnitude, contrast and brightness.
module mse_back
   import mse_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
   localparam int AW = $clog2(MAX_WIDTH),
   localparam int DATA_W = PIX_W + 2 * AW + $bits(mse_ctl_type)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [15:0]       contrast_gain,
   input  logic [8:0]        brightness_offset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  logic [DATA_W-1:0] pop_data,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata,   // out_red, out_green, out_blue
   output logic              rsp_tlast    // frame_last
);

   mse_back_state_type state_ff, state_in;

   logic [2*PIX_W-1:0] in_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] med_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] in_rd_ff, med_rd_ff;

   logic [PIX_W-1:0] pix_ff, mv_ff;
   logic [AW-1:0] laddr_ff, maddr_ff;
   mse_ctl_type ctl_ff;

   logic [PIX_W-1:0] q_pix;
   logic [AW-1:0] q_laddr, q_maddr;
   mse_ctl_type q_ctl;

   mse_win_type in_win_ff, med_win_ff;
   mse_nine_type part_ff [3];
   mse_nine_type med_done [3];
   logic [7:0] gray_ff [9];
   logic [7:0] gray_c [9];
   logic signed [11:0] gx, gy;
   logic [7:0] qx_ff, qy_ff;
   logic [16:0] sq_ff;
   logic [7:0] root_ff, trial;
   logic [15:0] trial_sq;
   logic [2:0] bit_ff;

   logic rsp_valid_ff, rsp_last_ff, rsp_free, load_rsp;
   logic [23:0] rsp_data_ff;
   logic [PIX_W-1:0] ctr;

   assign {q_pix, q_laddr, q_maddr, q_ctl} = pop_data;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         med_done[k] = med_net(part_ff[k], MED_SPLIT, MED_OPS - 1);
      end
      for (int i = 0; i < 9; i++) begin
         gray_c[i] = gray_of(med_win_ff[i / 3][i % 3]);
      end
      gx = (12'(gray_ff[2]) + 12'(gray_ff[5]) * 12'sd2 + 12'(gray_ff[8])) -
           (12'(gray_ff[0]) + 12'(gray_ff[3]) * 12'sd2 + 12'(gray_ff[6]));
      gy = (12'(gray_ff[0]) + 12'(gray_ff[1]) * 12'sd2 + 12'(gray_ff[2])) -
           (12'(gray_ff[6]) + 12'(gray_ff[7]) * 12'sd2 + 12'(gray_ff[8]));
      trial = root_ff | (8'd1 << bit_ff);
      trial_sq = 16'(trial) * 16'(trial);
      ctr = med_win_ff[1][1];
      rsp_free = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      state_in = state_ff;
      pop_ready = 1'b0;
      load_rsp = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               state_in = BK_WIN_IN;
            end
         end
         BK_WIN_IN: state_in = BK_MED1;
         BK_MED1: state_in = BK_MED2;
         BK_MED2: state_in = BK_WIN_MED;
         BK_WIN_MED: begin
            priority if (!ctl_ff.emit) begin
               state_in = BK_IDLE;
            end else if (ctl_ff.sobel) begin
               state_in = BK_GRAY;
            end else begin
               state_in = BK_FIN;
            end
         end
         BK_GRAY: state_in = BK_GRAD;
         BK_GRAD: state_in = BK_SQ;
         BK_SQ: state_in = BK_ROOT;
         BK_ROOT: begin
            if (bit_ff == 3'd0) begin
               state_in = BK_FIN;
            end
         end
         BK_FIN: begin
            if (rsp_free) begin
               load_rsp = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         in_win_ff <= '0;
         med_win_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == BK_WIN_IN) begin
            in_win_ff <= win_shift(in_win_ff, in_rd_ff[47:24], in_rd_ff[23:0], pix_ff);
         end
         if (state_ff == BK_WIN_MED) begin
            med_win_ff <= win_shift(med_win_ff, med_rd_ff[47:24], med_rd_ff[23:0], mv_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == BK_IDLE) begin
         in_rd_ff <= in_mem[q_laddr];
      end
      if (state_ff == BK_WIN_IN) begin
         in_mem[laddr_ff] <= {in_rd_ff[23:0], pix_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == BK_WIN_IN) begin
         med_rd_ff <= med_mem[maddr_ff];
      end
      if (state_ff == BK_WIN_MED) begin
         med_mem[maddr_ff] <= {med_rd_ff[23:0], mv_ff};
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         BK_IDLE: begin
            pix_ff <= q_pix;
            laddr_ff <= q_laddr;
            maddr_ff <= q_maddr;
            ctl_ff <= q_ctl;
         end
         BK_MED1: begin
            for (int k = 0; k < 3; k++) begin
               part_ff[k] <= med_net(chan_nine(in_win_ff, k), 0, MED_SPLIT - 1);
            end
         end
         BK_MED2: begin
            mv_ff <= ctl_ff.med ? {med_done[2][4], med_done[1][4], med_done[0][4]}
                                : in_win_ff[1][1];
         end
         BK_WIN_MED: root_ff <= 8'd0;
         BK_GRAY: begin
            for (int i = 0; i < 9; i++) begin
               gray_ff[i] <= gray_c[i];
            end
         end
         BK_GRAD: begin
            qx_ff <= (gx > 12'sd0) ? gx[9:2] : 8'd0;
            qy_ff <= (gy > 12'sd0) ? gy[9:2] : 8'd0;
         end
         BK_SQ: begin
            sq_ff <= 17'(16'(qx_ff) * 16'(qx_ff)) + 17'(16'(qy_ff) * 16'(qy_ff));
            root_ff <= 8'd0;
            bit_ff <= 3'd7;
         end
         BK_ROOT: begin
            if (17'(trial_sq) <= sq_ff) begin
               root_ff <= trial;
            end
            bit_ff <= bit_ff - 3'd1;
         end
         BK_FIN: begin
            if (load_rsp) begin
               rsp_data_ff <= {
                  finish_chan(ctr[7:0], root_ff, contrast_gain, $signed(brightness_offset)),
                  finish_chan(ctr[15:8], root_ff, contrast_gain, $signed(brightness_offset)),
                  finish_chan(ctr[23:16], root_ff, contrast_gain, $signed(brightness_offset))
               };
               rsp_last_ff <= ctl_ff.last;
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tlast = rsp_last_ff;

`ifndef NO_ASSERTIONS
   assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_ROOT |-> 17'(16'(root_ff) * 16'(root_ff)) <= sq_ff)
      else $error("root estimate exceeds radicand");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_IDLE && pop_valid |=> state_ff == BK_WIN_IN)
      else $error("popped beat not started");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == BK_FIN)
      else $error("result loaded outside finish step");
`endif

endmodule
